// ----- rtl/arpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ASCII run packet capper.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65535;

    localparam int LEN_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = LEN_W + PCT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
    localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RUN_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERCENT_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_LENGTH        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRINTABLE_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRINTABLE_HIGH    = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic             keep_whole;
        logic [LEN_W-1:0] stored_length;
        logic [LEN_W-1:0] captured_length;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]  run_threshold;
        logic [PCT_W-1:0]  percent_threshold;
        logic [LEN_W-1:0]  header_offset;
        logic [LEN_W-1:0]  cap_length;
        logic [BYTE_W-1:0] printable_low;
        logic [BYTE_W-1:0] printable_high;
    } cfg_t;

    // end-of-packet summary handed from the scanner to the decision stage
    typedef struct packed {
        logic [LEN_W-1:0] captured_length;
        logic [LEN_W-1:0] printable_count;
        logic             run_seen;
    } snap_t;

endpackage

// ----- rtl/arpc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module arpc_cfg
    import arpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RUN_THRESHOLD:     cfg_next.run_threshold     = cfg_data[LEN_W-1:0];
                REG_PERCENT_THRESHOLD: cfg_next.percent_threshold = cfg_data[PCT_W-1:0];
                REG_HEADER_OFFSET:     cfg_next.header_offset     = cfg_data[LEN_W-1:0];
                REG_CAP_LENGTH:        cfg_next.cap_length        = cfg_data[LEN_W-1:0];
                REG_PRINTABLE_LOW:     cfg_next.printable_low     = cfg_data[BYTE_W-1:0];
                REG_PRINTABLE_HIGH:    cfg_next.printable_high    = cfg_data[BYTE_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_threshold     <= 16'd8;
            cfg_reg.percent_threshold <= 7'd50;
            cfg_reg.header_offset     <= 16'd54;
            cfg_reg.cap_length        <= 16'd64;
            cfg_reg.printable_low     <= 8'd32;
            cfg_reg.printable_high    <= 8'd126;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/arpc_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_scan
// Input register and per-byte counters; emits a summary on each last byte.
// ----------------------------------------------------------------------------
module arpc_scan
    import arpc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  in_item_t byte_data,
    output logic     snap_valid,
    input  logic     snap_ready,
    output snap_t    snap
);

    localparam logic [LEN_W-1:0] POS_LIMIT = LEN_W'(MAX_PACKET_BYTES);

    logic             s1_valid_reg, s1_valid_next;
    in_item_t         s1_item_reg;
    logic             s2_valid_reg, s2_valid_next;
    snap_t            s2_snap_reg;

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] run_reg, run_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             seen_reg, seen_next;

    logic             byte_accept;
    logic             s1_adv;
    logic             s2_ready;
    logic             s2_load;

    logic             inspect;
    logic             printable;
    logic [LEN_W-1:0] pos_upd, run_upd, count_upd;
    logic             seen_upd;
    snap_t            snap_upd;

    assign s2_ready    = !s2_valid_reg || snap_ready;
    assign s1_adv      = s1_valid_reg && (!s1_item_reg.last_byte || s2_ready);
    assign s2_load     = s1_adv && s1_item_reg.last_byte;
    assign byte_stall  = s1_valid_reg && !s1_adv;
    assign byte_accept = byte_valid && !byte_stall;

    assign snap_valid  = s2_valid_reg;
    assign snap        = s2_snap_reg;

    always_comb
    begin
        inspect   = pos_reg >= cfg.header_offset;
        printable = (s1_item_reg.data_byte >= cfg.printable_low) &&
                    (s1_item_reg.data_byte <= cfg.printable_high);

        run_upd   = run_reg;
        count_upd = count_reg;
        seen_upd  = seen_reg;
        if (inspect)
        begin
            if (printable)
            begin
                run_upd   = (run_reg == LEN_MAX) ? run_reg : run_reg + 1'b1;
                count_upd = (count_reg == LEN_MAX) ? count_reg : count_reg + 1'b1;
                // a zero threshold never matches
                if ((cfg.run_threshold != '0) && (run_upd == cfg.run_threshold))
                begin
                    seen_upd = 1'b1;
                end
            end
            else
            begin
                run_upd = '0;
            end
        end

        // saturate the position; later bytes are judged as if at the limit
        pos_upd = (pos_reg < POS_LIMIT) ? pos_reg + 1'b1 : pos_reg;

        snap_upd.captured_length = pos_upd;
        snap_upd.printable_count = count_upd;
        snap_upd.run_seen        = seen_upd;

        pos_next   = pos_reg;
        run_next   = run_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        if (s1_adv)
        begin
            if (s1_item_reg.last_byte)
            begin
                pos_next   = '0;
                run_next   = '0;
                count_next = '0;
                seen_next  = 1'b0;
            end
            else
            begin
                pos_next   = pos_upd;
                run_next   = run_upd;
                count_next = count_upd;
                seen_next  = seen_upd;
            end
        end

        if (byte_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s2_load)
            s2_valid_next = 1'b1;
        else if (snap_ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pos_reg      <= '0;
            run_reg      <= '0;
            count_reg    <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            pos_reg      <= pos_next;
            run_reg      <= run_next;
            count_reg    <= count_next;
            seen_reg     <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
            s1_item_reg <= byte_data;
        if (s2_load)
            s2_snap_reg <= snap_upd;
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> (pos_reg == '0) && (run_reg == '0) && (count_reg == '0) && !seen_reg)
        else $error("packet state not cleared after last byte");

    a_snap_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_snap_reg.captured_length != '0))
        else $error("packet summary with zero length");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("held byte lost or changed");

endmodule

// ----- rtl/arpc_decide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_decide
// Product stage and result register: keep or cap one finished packet.
// ----------------------------------------------------------------------------
module arpc_decide
    import arpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      snap_valid,
    output logic      snap_ready,
    input  snap_t     snap,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_data
);

    logic              s3_valid_reg, s3_valid_next;
    logic [PROD_W-1:0] prod_count_reg;
    logic [PROD_W-1:0] prod_pct_reg;
    logic              short_reg;
    logic              seen_reg;
    logic [LEN_W-1:0]  captured_reg;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;
    out_item_t         out_item_upd;

    logic              out_ready;
    logic              s3_load;
    logic              s3_adv;
    logic [LEN_W-1:0]  inspected;
    logic              keep;

    assign out_ready    = !out_valid_reg || !result_stall;
    assign s3_adv       = s3_valid_reg && out_ready;
    assign snap_ready   = !s3_valid_reg || out_ready;
    assign s3_load      = snap_valid && snap_ready;

    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

    always_comb
    begin
        inspected = (snap.captured_length > cfg.header_offset) ?
                    snap.captured_length - cfg.header_offset : '0;

        keep = short_reg || seen_reg || (prod_count_reg >= prod_pct_reg);
        out_item_upd.keep_whole      = keep;
        out_item_upd.stored_length   = keep ? captured_reg : cfg.cap_length;
        out_item_upd.captured_length = captured_reg;

        if (s3_load)
            s3_valid_next = 1'b1;
        else if (s3_adv)
            s3_valid_next = 1'b0;
        else
            s3_valid_next = s3_valid_reg;

        if (s3_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            prod_count_reg <= PROD_W'(snap.printable_count) * PROD_W'(PCT_SCALE);
            prod_pct_reg   <= PROD_W'(cfg.percent_threshold) * PROD_W'(inspected);
            short_reg      <= snap.captured_length <= cfg.cap_length;
            seen_reg       <= snap.run_seen;
            captured_reg   <= snap.captured_length;
        end
        if (s3_adv)
            out_item_reg <= out_item_upd;
    end

    a_capped_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.keep_whole) |->
        (out_item_reg.stored_length == cfg.cap_length))
        else $error("capped packet not cut to cap length");

    a_kept_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.keep_whole) |->
        (out_item_reg.stored_length == out_item_reg.captured_length))
        else $error("kept packet length altered");

    a_capped_long: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.keep_whole) |->
        (out_item_reg.captured_length > cfg.cap_length))
        else $error("short packet was capped");

endmodule

// ----- rtl/ascii_run_packet_capper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_run_packet_capper
// Scans packet bytes for printable content and decides whether each packet
// is stored whole or cut to the cap length.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  byte     | byte_valid/byte_stall  | byte_data   (data_byte, last_byte)
//  result   | result_valid/_stall    | result_data (keep_whole, lengths)
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
//  A byte is taken every cycle while byte_stall is low; counters update as
//  it leaves the input register. A result passes the summary, product and
//  result registers; without a stall one packet may end in every cycle.
//  Reset clears the counters and loads the register defaults; no sweep.
//  A stalled result backs up the stages; a held last byte raises byte_stall.
// ----------------------------------------------------------------------------
module ascii_run_packet_capper
    import arpc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  in_item_t             byte_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_item_t            result_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t  cfg;
    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;

    arpc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    arpc_scan #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    arpc_decide u_decide
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule
